FILE: design/skeleton_forward_kinematics_defines.svh
// Assertion macros used by the skeleton forward kinematics top level.
`ifndef SKELETON_FORWARD_KINEMATICS_DEFINES_SVH
`define SKELETON_FORWARD_KINEMATICS_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Antecedent holds -> consequent holds in the same cycle.
`define SKF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("skf: same-cycle check failed");

// Antecedent holds -> consequent holds in the next cycle.
`define SKF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("skf: next-cycle check failed");

`else

`define SKF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SKF_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/skf_pkg.sv
// Types, constants and saturation helpers for the skeleton forward kinematics block.
package skf_pkg;

    localparam int BONE_W    = 6;
    localparam int PARENT_W  = BONE_W + 1;
    localparam int MAX_BONES = 1 << BONE_W;
    localparam int POS_W     = 32;
    localparam int ROT_W     = 16;

    localparam int FRAC_SHIFT = 14;
    localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);
    localparam int ROT_ONE    = 1 << FRAC_SHIFT;

    // Rotated offset: 32x16 products, difference, rounding bias.
    localparam int PROD_POS_W = POS_W + ROT_W;
    localparam int SUM_POS_W  = PROD_POS_W + 2;
    localparam int RPOS_W     = SUM_POS_W - FRAC_SHIFT;
    localparam int WPOS_W     = RPOS_W + 1;
    // Rotation product: 16x16 products, difference, rounding bias.
    localparam int PROD_ROT_W = 2 * ROT_W;
    localparam int SUM_ROT_W  = PROD_ROT_W + 2;
    localparam int RROT_W     = SUM_ROT_W - FRAC_SHIFT;

    localparam logic signed [PARENT_W-1:0] ROOT_PARENT = PARENT_W'(-1);

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_X   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_Y   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_COS = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIN = CFG_IDX_W'(3);

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [ROT_W-1:0] c;
        logic signed [ROT_W-1:0] s;
    } t_xform;

    localparam int XFORM_W = $bits(t_xform);

    // Clamp a widened position to the signed 32-bit range.
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WPOS_W-1:0] v);
        logic signed [WPOS_W-1:0] hi;
        logic signed [WPOS_W-1:0] lo;
        logic signed [POS_W-1:0]  r;
        hi = WPOS_W'({1'b0, {(POS_W-1){1'b1}}});
        lo = -hi - WPOS_W'(1);
        if (v > hi) begin
            r = POS_W'(hi);
        end else if (v < lo) begin
            r = POS_W'(lo);
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    // Clamp a rotation part to -1.0 .. +1.0 in Q1.14.
    function automatic logic signed [ROT_W-1:0] sat_rot(input logic signed [RROT_W-1:0] v);
        logic signed [RROT_W-1:0] one;
        logic signed [ROT_W-1:0]  r;
        one = RROT_W'(ROT_ONE);
        if (v > one) begin
            r = ROT_W'(ROT_ONE);
        end else if (v < -one) begin
            r = -ROT_W'(ROT_ONE);
        end else begin
            r = v[ROT_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: design/skf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module skf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents on a same-address write.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/skf_compose.sv
// Fixed-point composition of a parent transform with a local joint transform.
module skf_compose (
    input  skf_pkg::t_xform                   i_parent,
    input  logic signed [skf_pkg::POS_W-1:0] i_local_x,
    input  logic signed [skf_pkg::POS_W-1:0] i_local_y,
    input  logic signed [skf_pkg::ROT_W-1:0] i_local_cos,
    input  logic signed [skf_pkg::ROT_W-1:0] i_local_sin,
    output skf_pkg::t_xform                   o_world
);

    logic signed [skf_pkg::POS_W-1:0]      px;
    logic signed [skf_pkg::POS_W-1:0]      py;
    logic signed [skf_pkg::ROT_W-1:0]      pc;
    logic signed [skf_pkg::ROT_W-1:0]      ps;
    logic signed [skf_pkg::PROD_POS_W-1:0] p_xc;
    logic signed [skf_pkg::PROD_POS_W-1:0] p_ys;
    logic signed [skf_pkg::PROD_POS_W-1:0] p_xs;
    logic signed [skf_pkg::PROD_POS_W-1:0] p_yc;
    logic signed [skf_pkg::PROD_ROT_W-1:0] p_cc;
    logic signed [skf_pkg::PROD_ROT_W-1:0] p_ss;
    logic signed [skf_pkg::PROD_ROT_W-1:0] p_cs;
    logic signed [skf_pkg::PROD_ROT_W-1:0] p_sc;
    logic signed [skf_pkg::SUM_POS_W-1:0]  sum_x;
    logic signed [skf_pkg::SUM_POS_W-1:0]  sum_y;
    logic signed [skf_pkg::SUM_ROT_W-1:0]  sum_c;
    logic signed [skf_pkg::SUM_ROT_W-1:0]  sum_s;
    logic signed [skf_pkg::RPOS_W-1:0]     rx;
    logic signed [skf_pkg::RPOS_W-1:0]     ry;
    logic signed [skf_pkg::WPOS_W-1:0]     wx;
    logic signed [skf_pkg::WPOS_W-1:0]     wy;

    assign px = i_parent.x;
    assign py = i_parent.y;
    assign pc = i_parent.c;
    assign ps = i_parent.s;

    // Rotate the offset by the parent rotation.
    assign p_xc = i_local_x * pc;
    assign p_ys = i_local_y * ps;
    assign p_xs = i_local_x * ps;
    assign p_yc = i_local_y * pc;

    // Parent rotation times local rotation, as complex numbers.
    assign p_cc = pc * i_local_cos;
    assign p_ss = ps * i_local_sin;
    assign p_cs = pc * i_local_sin;
    assign p_sc = ps * i_local_cos;

    // Round half up, then floor-shift back to the stored format.
    assign sum_x = skf_pkg::SUM_POS_W'(p_xc) - skf_pkg::SUM_POS_W'(p_ys)
                 + skf_pkg::SUM_POS_W'(skf_pkg::ROUND_HALF);
    assign sum_y = skf_pkg::SUM_POS_W'(p_xs) + skf_pkg::SUM_POS_W'(p_yc)
                 + skf_pkg::SUM_POS_W'(skf_pkg::ROUND_HALF);
    assign sum_c = skf_pkg::SUM_ROT_W'(p_cc) - skf_pkg::SUM_ROT_W'(p_ss)
                 + skf_pkg::SUM_ROT_W'(skf_pkg::ROUND_HALF);
    assign sum_s = skf_pkg::SUM_ROT_W'(p_cs) + skf_pkg::SUM_ROT_W'(p_sc)
                 + skf_pkg::SUM_ROT_W'(skf_pkg::ROUND_HALF);

    assign rx = sum_x[skf_pkg::SUM_POS_W-1:skf_pkg::FRAC_SHIFT];
    assign ry = sum_y[skf_pkg::SUM_POS_W-1:skf_pkg::FRAC_SHIFT];

    assign wx = skf_pkg::WPOS_W'(px) + skf_pkg::WPOS_W'(rx);
    assign wy = skf_pkg::WPOS_W'(py) + skf_pkg::WPOS_W'(ry);

    assign o_world.x = skf_pkg::sat_pos(wx);
    assign o_world.y = skf_pkg::sat_pos(wy);
    assign o_world.c = skf_pkg::sat_rot(sum_c[skf_pkg::SUM_ROT_W-1:skf_pkg::FRAC_SHIFT]);
    assign o_world.s = skf_pkg::sat_rot(sum_s[skf_pkg::SUM_ROT_W-1:skf_pkg::FRAC_SHIFT]);

endmodule

FILE: design/skeleton_forward_kinematics.sv
// Top level of the skeleton forward kinematics block.
//
// Places a 2D bone hierarchy in world space, one bone item per clock when the output
// is not stalled. Bones arrive parent first; each item names its slot, its parent slot
// (-1 for the root), a Q16.16 offset and a Q1.14 unit rotation. The block returns one
// result item per bone: the world position (parent position plus the offset rotated by
// the parent rotation, saturated) and the world rotation (complex product, saturated to
// +-1.0). The root takes the base transform from the configuration registers. A bone
// whose parent has not been written in the current pose returns bad_parent with zero
// fields and stores nothing; new_pose forgets every written bone before the bone that
// carries it. Throughput is one item per cycle with no gaps while the result register
// is not stalled. An item is accepted into the stage register while the 64-entry world
// table (a RAM with registered read) fetches its parent; from the stage register the
// compose logic fills the result register, which offers the result, and writes the
// table. The bone placed in the immediately preceding cycle is forwarded from a bypass
// register, so a child may follow its parent back to back. Written marks live in
// flip-flops cleared at reset, so no clearing pass is needed after reset. Configuration
// is taken on any cycle; write it only while the block is idle.
module skeleton_forward_kinematics (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [skf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [skf_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // bone item input
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_new_pose,
    input  logic [skf_pkg::BONE_W-1:0]            i_bone_index,
    input  logic signed [skf_pkg::PARENT_W-1:0]   i_parent_index,
    input  logic signed [skf_pkg::POS_W-1:0]      i_local_x,
    input  logic signed [skf_pkg::POS_W-1:0]      i_local_y,
    input  logic signed [skf_pkg::ROT_W-1:0]      i_local_cos,
    input  logic signed [skf_pkg::ROT_W-1:0]      i_local_sin,
    // result item output
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [skf_pkg::POS_W-1:0]      o_world_x,
    output logic signed [skf_pkg::POS_W-1:0]      o_world_y,
    output logic signed [skf_pkg::ROT_W-1:0]      o_world_cos,
    output logic signed [skf_pkg::ROT_W-1:0]      o_world_sin,
    output logic                                  o_bad_parent
);

`include "skeleton_forward_kinematics_defines.svh"

    // ---------------------------------------------------------------- config
    logic signed [skf_pkg::POS_W-1:0] r_base_x;
    logic signed [skf_pkg::POS_W-1:0] r_base_y;
    logic signed [skf_pkg::ROT_W-1:0] r_base_cos;
    logic signed [skf_pkg::ROT_W-1:0] r_base_sin;
    logic                             cfg_fire;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid & o_cfg_ready;

    // Take a write at any index; drop indexes past the register list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_x   <= '0;
            r_base_y   <= '0;
            r_base_cos <= skf_pkg::ROT_W'(skf_pkg::ROT_ONE);
            r_base_sin <= '0;
        end else if (cfg_fire) begin
            unique case (i_cfg_index)
                skf_pkg::CFG_BASE_X:   r_base_x   <= i_cfg_data[skf_pkg::POS_W-1:0];
                skf_pkg::CFG_BASE_Y:   r_base_y   <= i_cfg_data[skf_pkg::POS_W-1:0];
                skf_pkg::CFG_BASE_COS: r_base_cos <= i_cfg_data[skf_pkg::ROT_W-1:0];
                skf_pkg::CFG_BASE_SIN: r_base_sin <= i_cfg_data[skf_pkg::ROT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- handshake
    logic in_fire;
    logic s1_adv;
    logic s1_fire;
    logic r_s1_valid;
    logic r_out_valid;

    // Stage 1 moves on whenever the result register is empty or being drained.
    assign s1_adv     = ~r_out_valid | i_out_ready;
    assign o_in_ready = ~r_s1_valid | s1_adv;
    assign in_fire    = i_in_valid & o_in_ready;
    assign s1_fire    = r_s1_valid & s1_adv;

    // ---------------------------------------------------------------- stage 1
    logic                                r_s1_new_pose;
    logic [skf_pkg::BONE_W-1:0]          r_s1_bone;
    logic signed [skf_pkg::PARENT_W-1:0] r_s1_parent;
    logic signed [skf_pkg::POS_W-1:0]    r_s1_lx;
    logic signed [skf_pkg::POS_W-1:0]    r_s1_ly;
    logic signed [skf_pkg::ROT_W-1:0]    r_s1_lc;
    logic signed [skf_pkg::ROT_W-1:0]    r_s1_ls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Hold the item while the result register is stalled.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_new_pose <= i_new_pose;
            r_s1_bone     <= i_bone_index;
            r_s1_parent   <= i_parent_index;
            r_s1_lx       <= i_local_x;
            r_s1_ly       <= i_local_y;
            r_s1_lc       <= i_local_cos;
            r_s1_ls       <= i_local_sin;
        end
    end

    // ---------------------------------------------------------------- world table
    logic [skf_pkg::XFORM_W-1:0] ram_rdata;
    logic                        wr_en;
    skf_pkg::t_xform             world;

    // Fetch the parent entry as the item enters; the read data holds during a stall.
    skf_ram #(
        .WIDTH (skf_pkg::XFORM_W),
        .DEPTH (skf_pkg::MAX_BONES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_bone),
        .i_wdata (world),
        .i_re    (in_fire),
        .i_raddr (i_parent_index[skf_pkg::BONE_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // Bypass: the last bone written. The RAM read taken in the same cycle misses it.
    logic                       r_fwd_valid;
    logic [skf_pkg::BONE_W-1:0] r_fwd_index;
    skf_pkg::t_xform            r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (wr_en) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_fwd_index <= r_s1_bone;
            r_fwd_data  <= world;
        end
    end

    // Written marks, one flop per slot.
    logic [skf_pkg::MAX_BONES-1:0] r_marks;
    logic [skf_pkg::MAX_BONES-1:0] n_marks;

    // ---------------------------------------------------------------- parent select
    logic                       parent_root;
    logic                       parent_in_range;
    logic [skf_pkg::BONE_W-1:0] parent_slot;
    logic                       mark_hit;
    logic                       fwd_hit;
    logic                       place_ok;
    skf_pkg::t_xform            parent_xf;
    skf_pkg::t_xform            base_xf;

    assign base_xf = '{x: r_base_x, y: r_base_y, c: r_base_cos, s: r_base_sin};

    assign parent_root     = (r_s1_parent == skf_pkg::ROOT_PARENT);
    // Every non-negative parent code names a real slot; other negatives never do.
    assign parent_in_range = ~r_s1_parent[skf_pkg::PARENT_W-1];
    assign parent_slot     = r_s1_parent[skf_pkg::BONE_W-1:0];
    // new_pose drops all marks ahead of this bone's own lookup.
    assign mark_hit        = ~r_s1_new_pose & r_marks[parent_slot];
    assign fwd_hit         = r_fwd_valid & (r_fwd_index == parent_slot);
    // The bone slot field cannot exceed the table, so only the parent can fail.
    assign place_ok        = parent_root | (parent_in_range & mark_hit);

    always_comb begin
        priority if (parent_root) begin
            parent_xf = base_xf;
        end else if (fwd_hit) begin
            parent_xf = r_fwd_data;
        end else begin
            parent_xf = skf_pkg::t_xform'(ram_rdata);
        end
    end

    skf_compose u_compose (
        .i_parent    (parent_xf),
        .i_local_x   (r_s1_lx),
        .i_local_y   (r_s1_ly),
        .i_local_cos (r_s1_lc),
        .i_local_sin (r_s1_ls),
        .o_world     (world)
    );

    assign wr_en = s1_fire & place_ok;

    always_comb begin
        n_marks = r_marks;
        if (s1_fire) begin
            if (r_s1_new_pose) begin
                n_marks = '0;
            end
            if (place_ok) begin
                n_marks[r_s1_bone] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks <= '0;
        end else begin
            r_marks <= n_marks;
        end
    end

    // ---------------------------------------------------------------- result register
    skf_pkg::t_xform r_out_xf;
    logic            r_out_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // Zero the fields of a bone that could not be placed.
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_xf  <= place_ok ? world : '0;
            r_out_bad <= ~place_ok;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_world_x    = r_out_xf.x;
    assign o_world_y    = r_out_xf.y;
    assign o_world_cos  = r_out_xf.c;
    assign o_world_sin  = r_out_xf.s;
    assign o_bad_parent = r_out_bad;

    // ---------------------------------------------------------------- checks
    `SKF_ASSERT_IMP(a_bad_is_zero, i_clk, i_rst_n, o_out_valid && o_bad_parent,
        r_out_xf == '0)
    `SKF_ASSERT_NXT(a_s1_holds, i_clk, i_rst_n, r_s1_valid && !s1_adv,
        r_s1_valid && $stable(r_s1_bone) && $stable(r_s1_parent))
    `SKF_ASSERT_NXT(a_write_marks, i_clk, i_rst_n, wr_en,
        r_fwd_valid && r_marks[r_fwd_index])
    `SKF_ASSERT_NXT(a_pose_clears, i_clk, i_rst_n, s1_fire && r_s1_new_pose && !place_ok,
        r_marks == '0)

endmodule
